FILE: design/dws_pkg.sv
// Package for the deflate wrapper stripper: mode codes, gzip flag bits,
// trailer store sizing and the parser-to-datapath action struct.
// No dependencies.
`default_nettype none
package dws_pkg;

  localparam int TRAILER_MAX = 8;
  localparam int AW          = $clog2(TRAILER_MAX);
  localparam int CW          = $clog2(TRAILER_MAX + 1);

  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_ZLIB = 2'd1;
  localparam logic [1:0] MODE_GZIP = 2'd2;

  localparam logic [CW-1:0] ZLIB_TRAILER = CW'(4);
  localparam logic [CW-1:0] GZIP_TRAILER = CW'(TRAILER_MAX);
  localparam logic [3:0]    ZLIB_HEAD    = 4'd2;
  localparam logic [3:0]    GZIP_HEAD    = 4'd10;
  localparam logic [3:0]    FLG_POS      = 4'd3;
  localparam logic [3:0]    HCRC_LEN     = 4'd2;

  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  typedef struct packed {
    logic          res_valid;
    logic          from_mem;
    logic [7:0]    byte_val;
    logic          last;
    logic          error;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
  } dws_act_t;

endpackage
`default_nettype wire

FILE: design/dws_trailer_ram.sv
// Trailer delay store: one write port, one read port with registered data.
// Generic RAM, no package dependency.
`default_nettype none
module dws_trailer_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: design/dws_parser.sv
// Wrapper parser: header state machine, mode register and trailer store
// pointers. Depends on dws_pkg; drives one action per accepted item.
`default_nettype none
module dws_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              in_acc,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output dws_pkg::dws_act_t      act
);
  import dws_pkg::*;

  typedef enum logic [2:0] {
    PH_FIXED, PH_XLEN, PH_XDATA, PH_NAME, PH_COMMENT, PH_HCRC, PH_BODY
  } phase_t;

  logic [1:0]    mode_r;
  phase_t        phase_r, phase_nxt;
  logic [3:0]    hcnt_r, hcnt_nxt;
  logic [4:0]    flags_r, flags_nxt;
  logic [15:0]   xlen_r, xlen_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] tlen;
  logic          body;
  logic          emit_direct;
  logic          emit_mem;

  function automatic phase_t next_phase(input phase_t from, input logic [4:0] flg);
    phase_t p;
    if (from < PH_XLEN && flg[FLG_EXTRA]) p = PH_XLEN;
    else if (from < PH_NAME && flg[FLG_NAME]) p = PH_NAME;
    else if (from < PH_COMMENT && flg[FLG_COMMENT]) p = PH_COMMENT;
    else if (from < PH_HCRC && flg[FLG_HCRC]) p = PH_HCRC;
    else p = PH_BODY;
    return p;
  endfunction

  always_comb begin
    unique case (mode_r)
      MODE_ZLIB: tlen = ZLIB_TRAILER;
      MODE_GZIP: tlen = GZIP_TRAILER;
      default:   tlen = '0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    flags_nxt = flags_r;
    xlen_nxt  = xlen_r;
    body      = 1'b0;
    unique case (phase_r)
      PH_FIXED: begin
        if (mode_r == MODE_ZLIB) begin
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_nxt >= ZLIB_HEAD) begin
            phase_nxt = PH_BODY;
            hcnt_nxt  = '0;
          end
        end else if (mode_r == MODE_GZIP) begin
          if (hcnt_r == FLG_POS) flags_nxt = in_byte[4:0];
          hcnt_nxt = hcnt_r + 4'd1;
          if (hcnt_nxt >= GZIP_HEAD) begin
            phase_nxt = next_phase(PH_FIXED, flags_r);
            hcnt_nxt  = '0;
          end
        end else begin
          phase_nxt = PH_BODY;
          hcnt_nxt  = '0;
          body      = 1'b1;
        end
      end
      PH_XLEN: begin
        if (hcnt_r == 4'd0) begin
          xlen_nxt = {8'd0, in_byte};
          hcnt_nxt = 4'd1;
        end else begin
          xlen_nxt  = {in_byte, xlen_r[7:0]};
          hcnt_nxt  = '0;
          phase_nxt = (xlen_nxt == 16'd0) ? next_phase(PH_XDATA, flags_r) : PH_XDATA;
        end
      end
      PH_XDATA: begin
        if (xlen_r != 16'd0) xlen_nxt = xlen_r - 16'd1;
        if (xlen_nxt == 16'd0) begin
          phase_nxt = next_phase(PH_XDATA, flags_r);
          hcnt_nxt  = '0;
        end
      end
      PH_NAME, PH_COMMENT: begin
        if (in_byte == 8'd0) begin
          phase_nxt = next_phase(phase_r, flags_r);
          hcnt_nxt  = '0;
        end
      end
      PH_HCRC: begin
        hcnt_nxt = hcnt_r + 4'd1;
        if (hcnt_nxt >= HCRC_LEN) begin
          phase_nxt = PH_BODY;
          hcnt_nxt  = '0;
        end
      end
      default: begin
        body = 1'b1;
      end
    endcase
  end

  always_comb begin
    fill_nxt    = fill_r;
    ptr_nxt     = ptr_r;
    emit_direct = 1'b0;
    emit_mem    = 1'b0;
    act.wr_en   = 1'b0;
    if (body) begin
      if (tlen == '0) begin
        emit_direct = 1'b1;
      end else begin
        act.wr_en = 1'b1;
        ptr_nxt   = ptr_r + AW'(1);
        if (fill_r < tlen) fill_nxt = fill_r + CW'(1);
        else emit_mem = 1'b1;
      end
    end
    act.wr_addr   = ptr_r;
    act.rd_en     = in_acc && emit_mem;
    act.rd_addr   = ptr_r - tlen[AW-1:0];
    act.from_mem  = emit_mem;
    act.byte_val  = in_byte;
    act.res_valid = emit_direct || emit_mem || in_last;
    act.last      = in_last;
    act.error     = in_last && !(emit_direct || emit_mem);
    act.wr_en     = act.wr_en && in_acc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_GZIP;
      phase_r <= PH_FIXED;
      hcnt_r  <= '0;
      flags_r <= '0;
      xlen_r  <= '0;
      fill_r  <= '0;
      ptr_r   <= '0;
    end else if (cfg_we) begin
      mode_r  <= cfg_wdata;
      phase_r <= PH_FIXED;
      hcnt_r  <= '0;
      flags_r <= '0;
      xlen_r  <= '0;
      fill_r  <= '0;
      ptr_r   <= '0;
    end else if (in_acc) begin
      if (in_last) begin
        phase_r <= PH_FIXED;
        hcnt_r  <= '0;
        flags_r <= '0;
        xlen_r  <= '0;
        fill_r  <= '0;
        ptr_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        hcnt_r  <= hcnt_nxt;
        flags_r <= flags_nxt;
        xlen_r  <= xlen_nxt;
        fill_r  <= fill_nxt;
        ptr_r   <= ptr_nxt;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/deflate_wrapper_stripper_top.sv
// Top level of the deflate wrapper stripper: parser, trailer store RAM,
// read stage and output register. Depends on dws_pkg, dws_parser, dws_trailer_ram.
//
// Usage:
//   in_*  : one wrapped stream byte per item, in_tlast on the final byte.
//   out_* : raw deflate body bytes; tuser flags valid byte and error,
//           tlast closes the stream. Header and trailer bytes give no item;
//           the final input byte always gives exactly one item.
//   cfg_* : cfg_we writes wrapper_mode (0 raw, 1 zlib, 2 gzip, 3 raw) and
//           restarts the parser; write only while the block is idle.
// Throughput: one byte per cycle while out_tready keeps the output moving, set by
//   the parser updating once per byte and the one read plus one write per cycle
//   on the trailer store. Path: a result accepted on in_* passes the store read
//   stage, then the output register, before it is offered on out_*; a stall
//   can hold it in either.
// Reset: mode returns to gzip, parser to the start of a stream, pipeline
//   empties. The store holds no reset value; only written entries are read.
// Stall: when out_tready is low the output register holds its item, the
//   read stage still fills, and then in_tready drops until space frees.
`default_nettype none
module deflate_wrapper_stripper_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,     // wrapper_mode
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,      // [7:0] in_byte
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,     // [7:0] out_byte
  output logic      [1:0] out_tuser,     // [0] out_valid, [1] out_error
  output logic            out_tlast
);
  import dws_pkg::*;

  dws_act_t   act;
  logic       in_acc;
  logic [7:0] rd_data;
  logic       s1_valid_r;
  logic       s1_from_mem_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_err_r;
  logic       s1_move;
  logic [7:0] s1_out_byte;
  logic       s2_valid_r;
  logic [7:0] s2_byte_r;
  logic [1:0] s2_user_r;
  logic       s2_last_r;

  assign s1_move   = s1_valid_r && (!s2_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;

  dws_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .act       (act)
  );

  dws_trailer_ram #(
    .DEPTH (TRAILER_MAX),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (act.wr_en),
    .wr_addr (act.wr_addr),
    .wr_data (in_tdata),
    .rd_en   (act.rd_en),
    .rd_addr (act.rd_addr),
    .rd_data (rd_data)
  );

  assign s1_out_byte = s1_err_r ? 8'd0 : (s1_from_mem_r ? rd_data : s1_byte_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= act.res_valid;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_from_mem_r <= act.from_mem;
      s1_byte_r     <= act.byte_val;
      s1_last_r     <= act.last;
      s1_err_r      <= act.error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r <= 1'b1;
    end else if (out_tready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_byte_r <= s1_out_byte;
      s2_user_r <= {s1_err_r, !s1_err_r};
      s2_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_byte_r;
  assign out_tuser  = s2_user_r;
  assign out_tlast  = s2_last_r;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for deflate_wrapper_stripper_top: streams directed and random raw, zlib
// and gzip byte sequences through the block and checks every output item in order
// against an in-bench parser model. Depends on dws_pkg and the design files.
module testbench;
  import dws_pkg::*;

  localparam logic [1:0] MODE_RAW_ALT = 2'd3;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 150;

  typedef enum logic [3:0] {
    PH_FIXED, PH_XLEN, PH_XDATA, PH_NAME, PH_COMMENT, PH_HCRC, PH_BODY
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       error;
  } body_result_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_we     = 1'b0;
  logic [1:0] cfg_wdata  = MODE_RAW;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  logic       in_tready;
  logic       out_tvalid;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  stream_byte_t pending_bytes[$];
  body_result_t expected_bytes[$];
  logic [7:0]   wrk[$];

  int queued_cnt   = 0;
  int accepted_cnt = 0;
  int results_cnt  = 0;
  int error_cnt    = 0;
  int cfg_cnt      = 0;
  int stream_cnt   = 0;
  int cycle_cnt    = 0;

  // parser model state
  logic [1:0]   strip_mode = MODE_GZIP;
  parse_phase_e phase;
  int           hdr_cnt;
  logic [4:0]   flags_kept;
  int           extra_left;
  logic [7:0]   trailer_mem [TRAILER_MAX];
  int           fill_cnt;
  int           wr_ptr;

  // driver and receiver pacing
  int           tx_gap = 0, tx_burst = 0, rx_gap = 0, rx_burst = 0;
  bit           tx_calm = 0, rx_calm = 0;
  stream_byte_t tx_item;
  body_result_t seen_exp;
  int           hold_left = 0;
  bit           hold_done = 0;
  logic         hold_active = 1'b0;

  deflate_wrapper_stripper_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic parse_phase_e next_part(parse_phase_e from);
    if (from < PH_XLEN && flags_kept[FLG_EXTRA]) return PH_XLEN;
    if (from < PH_NAME && flags_kept[FLG_NAME]) return PH_NAME;
    if (from < PH_COMMENT && flags_kept[FLG_COMMENT]) return PH_COMMENT;
    if (from < PH_HCRC && flags_kept[FLG_HCRC]) return PH_HCRC;
    return PH_BODY;
  endfunction

  task automatic restart_parse();
    phase      = PH_FIXED;
    hdr_cnt    = 0;
    flags_kept = '0;
    extra_left = 0;
    fill_cnt   = 0;
    wr_ptr     = 0;
  endtask

  task automatic enter_part(parse_phase_e p);
    phase   = p;
    hdr_cnt = 0;
  endtask

  task automatic body_through(input logic [7:0] b, output bit leaves, output logic [7:0] lv);
    int tlen;
    int rd_idx;
    tlen = (strip_mode == MODE_ZLIB) ? int'(ZLIB_TRAILER) :
           (strip_mode == MODE_GZIP) ? int'(GZIP_TRAILER) : 0;
    leaves = 0;
    lv     = 8'h00;
    if (tlen == 0) begin
      leaves = 1;
      lv     = b;
    end else begin
      if (fill_cnt >= tlen) begin
        leaves = 1;
        rd_idx = (wr_ptr + TRAILER_MAX - fill_cnt) % TRAILER_MAX;
        lv     = trailer_mem[rd_idx[AW-1:0]];
      end else begin
        fill_cnt++;
      end
      trailer_mem[wr_ptr[AW-1:0]] = b;
      wr_ptr = (wr_ptr + 1) % TRAILER_MAX;
    end
  endtask

  task automatic predict_strip(input logic [7:0] b, input logic l);
    bit           leaves;
    logic [7:0]   lv;
    body_result_t r;
    leaves = 0;
    lv     = 8'h00;
    case (phase)
      PH_FIXED: begin
        if (strip_mode == MODE_ZLIB) begin
          hdr_cnt++;
          if (hdr_cnt >= ZLIB_HEAD) enter_part(PH_BODY);
        end else if (strip_mode == MODE_GZIP) begin
          if (hdr_cnt == FLG_POS) flags_kept = b[4:0];
          hdr_cnt++;
          if (hdr_cnt >= GZIP_HEAD) enter_part(next_part(PH_FIXED));
        end else begin
          enter_part(PH_BODY);
          body_through(b, leaves, lv);
        end
      end
      PH_XLEN: begin
        if (hdr_cnt == 0) begin
          extra_left = int'(b);
          hdr_cnt    = 1;
        end else begin
          extra_left = extra_left | (int'(b) << 8);
          if (extra_left == 0) enter_part(next_part(PH_XDATA));
          else enter_part(PH_XDATA);
        end
      end
      PH_XDATA: begin
        if (extra_left > 0) extra_left--;
        if (extra_left == 0) enter_part(next_part(PH_XDATA));
      end
      PH_NAME, PH_COMMENT: begin
        if (b == 8'h00) enter_part(next_part(phase));
      end
      PH_HCRC: begin
        hdr_cnt++;
        if (hdr_cnt >= HCRC_LEN) enter_part(PH_BODY);
      end
      default: body_through(b, leaves, lv);
    endcase
    if (l) begin
      r.data  = leaves ? lv : 8'h00;
      r.valid = leaves;
      r.last  = 1'b1;
      r.error = !leaves;
      expected_bytes.push_back(r);
      restart_parse();
    end else if (leaves) begin
      r.data  = lv;
      r.valid = 1'b1;
      r.last  = 1'b0;
      r.error = 1'b0;
      expected_bytes.push_back(r);
    end
  endtask

  function automatic int next_gap(inout int burst, inout bit calm);
    int r;
    if (burst <= 0) begin
      burst = $urandom_range(40, 4);
      calm  = ($urandom_range(3, 0) == 0);
    end
    burst--;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    error_cnt++;
    $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  task automatic push_item(logic [7:0] b, logic l);
    stream_byte_t it;
    it.data = b;
    it.last = l;
    pending_bytes.push_back(it);
    queued_cnt++;
  endtask

  task automatic add_rand(int n, bit nonzero);
    for (int k = 0; k < n; k++) wrk.push_back(8'($urandom_range(255, nonzero)));
  endtask

  // well-formed stream most of the time, else a truncated one or plain noise
  task automatic make_stream(logic [1:0] m, bit closed);
    int         kind, cut, xl, k, blen;
    logic [7:0] flg;
    wrk.delete();
    kind = $urandom_range(99, 0);
    blen = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(24, 1);
    if (kind >= 92) begin
      add_rand($urandom_range(30, 1), 0);
    end else begin
      if (m == MODE_GZIP) begin
        add_rand(GZIP_HEAD, 0);
        flg = 8'($urandom_range(255, 0));
        wrk[FLG_POS] = flg;
        if (flg[FLG_EXTRA]) begin
          k  = $urandom_range(99, 0);
          xl = (k < 90) ? $urandom_range(6, 0) :
               (k < 97) ? $urandom_range(40, 7) : $urandom_range(300, 256);
          wrk.push_back(xl[7:0]);
          wrk.push_back(xl[15:8]);
          add_rand(xl, 0);
        end
        if (flg[FLG_NAME]) begin
          add_rand($urandom_range(5, 0), 1);
          wrk.push_back(8'h00);
        end
        if (flg[FLG_COMMENT]) begin
          add_rand($urandom_range(5, 0), 1);
          wrk.push_back(8'h00);
        end
        if (flg[FLG_HCRC]) add_rand(HCRC_LEN, 0);
        add_rand(blen, 0);
        add_rand(GZIP_TRAILER, 0);
      end else if (m == MODE_ZLIB) begin
        add_rand(ZLIB_HEAD, 0);
        add_rand(blen, 0);
        add_rand(ZLIB_TRAILER, 0);
      end else begin
        add_rand($urandom_range(24, 1), 0);
      end
      if (kind >= 80) begin
        cut = $urandom_range(wrk.size(), 1);
        while (wrk.size() > cut) void'(wrk.pop_back());
      end
    end
    for (k = 0; k < wrk.size(); k++) push_item(wrk[k], closed && (k == wrk.size() - 1));
    stream_cnt++;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (accepted_cnt != queued_cnt || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we     <= 1'b0;
    strip_mode  = m;
    restart_parse();
    cfg_cnt++;
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_strip(in_tdata, in_tlast);
        accepted_cnt++;
      end
      if ((in_tvalid && in_tready) || !in_tvalid) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          tx_item    = pending_bytes.pop_front();
          in_tdata  <= tx_item.data;
          in_tlast  <= tx_item.last;
          in_tvalid <= 1'b1;
          tx_gap     = next_gap(tx_burst, tx_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_active <= 1'b0;
    end else if (hold_active) begin
      hold_left--;
      if (hold_left == 0) begin
        hold_active <= 1'b0;
        hold_done    = 1;
      end
    end else if (!hold_done && results_cnt >= HOLD_AFTER) begin
      hold_left    = HOLD_CYCLES;
      hold_active <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || hold_active) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) rx_gap = next_gap(rx_burst, rx_calm);
      out_tready <= (rx_gap == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_cnt++;
      if (expected_bytes.size() == 0) begin
        report("item with nothing expected", {8'h00, out_tdata}, 16'h0000);
      end else begin
        seen_exp = expected_bytes.pop_front();
        if (out_tdata !== seen_exp.data)
          report("out_byte", 16'(out_tdata), 16'(seen_exp.data));
        if (out_tuser[0] !== seen_exp.valid)
          report("out_valid", 16'(out_tuser[0]), 16'(seen_exp.valid));
        if (out_tuser[1] !== seen_exp.error)
          report("out_error", 16'(out_tuser[1]), 16'(seen_exp.error));
        if (out_tlast !== seen_exp.last)
          report("out_last", 16'(out_tlast), 16'(seen_exp.last));
      end
    end
  end

  initial begin
    logic [7:0] gz_hdr [10];
    logic [1:0] mode_order [4];
    logic [1:0] m;
    int         rnd_start, ph;
    gz_hdr     = '{8'h1F, 8'h8B, 8'h08, 8'h06, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    mode_order = '{MODE_RAW, MODE_ZLIB, MODE_GZIP, MODE_RAW_ALT};
    restart_parse();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // gzip after reset: zero-length extra field, header CRC, body too short
    for (int k = 0; k < 10; k++) push_item(gz_hdr[4'(k)], 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    set_mode(MODE_RAW);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b1);
    set_mode(MODE_RAW_ALT);
    push_item(8'h5A, 1'b0);
    push_item(8'hA5, 1'b1);
    // zlib: end inside the header, then an empty body
    set_mode(MODE_ZLIB);
    push_item(8'h78, 1'b1);
    push_item(8'h78, 1'b0);
    push_item(8'h9C, 1'b0);
    push_item(8'h00, 1'b1);

    rnd_start = queued_cnt;
    ph = 0;
    while (queued_cnt - rnd_start < RANDOM_ITEMS) begin
      if (ph < 4) m = mode_order[2'(ph)];
      else if ($urandom_range(1, 0) == 1) m = MODE_GZIP;
      else m = mode_order[2'($urandom_range(3, 0))];
      set_mode(m);
      repeat ($urandom_range(6, 1)) make_stream(m, 1'b1);
      // leave a stream open so the next mode write aborts it
      if ($urandom_range(3, 0) == 0) make_stream(m, 1'b0);
      ph++;
    end

    wait_idle();
    $display("tb: %0d streams over %0d mode settings, %0d bytes in, %0d items out checked",
             stream_cnt, cfg_cnt, accepted_cnt, results_cnt);
    if (expected_bytes.size() != 0)
      report("items never seen", 16'h0000, 16'(expected_bytes.size()));
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
